// ===== src/assert_macros.svh =====
// Assertion helpers for the voice slot allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// a concurrent check, disabled while reset is applied
`define VSA_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("voice slot allocator check failed");
// the same check, never disabled
`define VSA_CHECK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("voice slot allocator check failed");
`else
`define VSA_CHECK(label, clk, rst_n, prop)
`define VSA_CHECK_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/vsa_pkg.sv =====
`default_nettype none

package vsa_pkg;

    // defaults for the top level parameters
    localparam int DEF_NUM_SLOTS  = 64;
    localparam int DEF_OWNER_BITS = 32;
    localparam int DEF_AGE_BITS   = 32;

    // opcodes
    localparam logic [3:0] OP_ALLOC   = 4'd0;
    localparam logic [3:0] OP_FREE    = 4'd1;
    localparam logic [3:0] OP_SET_PRI = 4'd2;
    localparam logic [3:0] OP_HANDLER = 4'd3;
    localparam logic [3:0] OP_PLAY    = 4'd4;
    localparam logic [3:0] OP_STOP    = 4'd5;
    localparam logic [3:0] OP_BRK_LO  = 4'd6;
    localparam logic [3:0] OP_BRK_ACT = 4'd7;
    localparam logic [3:0] OP_TICK    = 4'd8;

    // result status codes
    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_NONE_FREE = 3'd1;
    localparam logic [2:0] RC_BAD_OWNER = 3'd2;
    localparam logic [2:0] RC_MULTI     = 3'd3;
    localparam logic [2:0] RC_REFUSED   = 3'd4;

    // slot status codes
    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_FREE  = 2'd1;
    localparam logic [1:0] ST_STOP  = 2'd2;

    // starting priority of the victim search
    localparam logic [7:0] PRI_START = 8'hff;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [5:0]  slot;
        logic [31:0] owner;
        logic [7:0]  value;
    } req_word_t;

    typedef struct packed {
        logic [2:0] status_code;
        logic [5:0] result_slot;
        logic       victim_notified;
        logic [6:0] free_count;
        logic [6:0] use_count;
        logic [6:0] break_count;
    } rsp_word_t;

endpackage

`default_nettype wire

// ===== src/voice_slot_allocator_with_stealing.sv =====
`default_nettype none

// Voice slot allocator with voice stealing. All slot records (status, owner,
// priority, handler, active, forced stop, age) live in one synchronous RAM;
// a controller reads, modifies and writes them back one word at a time.
// After reset a clearing pass writes every record, during which req_stall
// stays high. One request word is handled at a time: free, set priority,
// attach handler, play and stop pass through read, modify-write, then the
// respond step, which raises rsp_valid; alloc, both break operations and
// tick sweep the RAM at one slot per cycle (a break adds a decide step;
// alloc and break lower finish early at the first free slot). The single
// RAM read port sets that rate. A multichannel alloc, an out-of-range single
// slot request or an unknown opcode goes straight to the respond step. Once
// the response word is loaded the controller returns to idle, where it takes
// the next request word. A response waiting on rsp_stall holds the
// controller in its respond step. The free, in-use and stopped counts are
// kept in registers beside the RAM.
module voice_slot_allocator_with_stealing #(
    parameter int NUM_SLOTS  = vsa_pkg::DEF_NUM_SLOTS,
    parameter int OWNER_BITS = vsa_pkg::DEF_OWNER_BITS,
    parameter int AGE_BITS   = vsa_pkg::DEF_AGE_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire vsa_pkg::req_word_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output vsa_pkg::rsp_word_t     rsp
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    // one slot record as held in the RAM
    typedef struct packed {
        logic [1:0]            status;
        logic [OWNER_BITS-1:0] owner;
        logic [7:0]            pri;
        logic                  handler;
        logic                  active;
        logic                  fstop;
        logic [AGE_BITS-1:0]   age;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_ONE    = 6'b001000,
        S_DECIDE = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [3:0]            op_reg, op_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [OWNER_BITS-1:0] own_reg, own_next;
    logic [7:0]            val_reg, val_next;

    // sweep: issue side and evaluate side
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic              issue_reg, issue_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [SLOT_W-1:0] ev_idx_reg, ev_idx_next;
    logic              ev_last_reg, ev_last_next;
    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;

    // victim search
    logic [SLOT_W-1:0]   vic_idx_reg, vic_idx_next;
    rec_t                vic_rec_reg, vic_rec_next;
    logic [7:0]          cmp_pri_reg, cmp_pri_next;
    logic [AGE_BITS-1:0] cmp_age_reg, cmp_age_next;

    // result being built
    logic [2:0]        res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_note_reg, res_note_next;

    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0] use_cnt_reg, use_cnt_next;
    logic [CNT_W-1:0] stop_cnt_reg, stop_cnt_next;

    logic               rsp_valid_reg, rsp_valid_next;
    vsa_pkg::rsp_word_t rsp_reg, rsp_next;

    // RAM ports
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    rec_t              wr_rec;
    logic [SLOT_W-1:0] rd_addr;
    logic [REC_W-1:0]  rd_data;
    rec_t              rd_rec;

    rec_t              reset_rec;
    logic              req_in_range;
    logic [SLOT_W-1:0] req_idx;
    logic [7:0]        best_pri;
    logic [AGE_BITS-1:0] best_age;
    logic              take_free;
    logic              is_cand;
    logic              pool_ok;

    vsa_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (REC_W),
        .AW    (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_rec       = rec_t'(rd_data);
    assign req_idx      = SLOT_W'(req.slot);
    assign req_in_range = int'(req.slot) < NUM_SLOTS;
    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

    always_comb
    begin
        reset_rec        = '0;
        reset_rec.status = vsa_pkg::ST_FREE;
    end

    // search metrics: slot 0 starts from the initial values
    assign best_pri  = (ev_idx_reg == '0) ? vsa_pkg::PRI_START : cmp_pri_reg;
    assign best_age  = (ev_idx_reg == '0) ? '0 : cmp_age_reg;
    assign take_free = (op_reg == vsa_pkg::OP_BRK_LO);
    assign is_cand   = (rd_rec.status == vsa_pkg::ST_ALLOC)
                     && (!take_free || rd_rec.handler)
                     && (rd_rec.pri <= best_pri)
                     && ((rd_rec.pri != best_pri) || (rd_rec.age >= best_age));

    // every slot is counted exactly once
    assign pool_ok = (32'(free_cnt_reg) + 32'(use_cnt_reg) + 32'(stop_cnt_reg))
                     == 32'(NUM_SLOTS);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        own_next        = own_reg;
        val_next        = val_reg;
        rd_idx_next     = rd_idx_reg;
        issue_next      = issue_reg;
        ev_valid_next   = 1'b0;
        ev_idx_next     = ev_idx_reg;
        ev_last_next    = ev_last_reg;
        clr_idx_next    = clr_idx_reg;
        vic_idx_next    = vic_idx_reg;
        vic_rec_next    = vic_rec_reg;
        cmp_pri_next    = cmp_pri_reg;
        cmp_age_next    = cmp_age_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_note_next   = res_note_reg;
        free_cnt_next   = free_cnt_reg;
        use_cnt_next    = use_cnt_reg;
        stop_cnt_next   = stop_cnt_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        wr_en           = 1'b0;
        wr_addr         = ev_idx_reg;
        wr_rec          = rd_rec;
        rd_addr         = rd_idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_rec       = reset_rec;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                // read the target slot now; single slot ops use it next cycle
                rd_addr = req_idx;
                if (req_valid)
                begin
                    op_next         = req.opcode;
                    idx_next        = req_idx;
                    own_next        = OWNER_BITS'(req.owner);
                    val_next        = req.value;
                    res_status_next = vsa_pkg::RC_OK;
                    res_slot_next   = '0;
                    res_note_next   = 1'b0;
                    rd_idx_next     = '0;
                    issue_next      = 1'b1;
                    case (req.opcode)
                        vsa_pkg::OP_ALLOC:
                        begin
                            if (req.value != 8'd0)
                            begin
                                res_status_next = vsa_pkg::RC_MULTI;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                res_status_next = vsa_pkg::RC_NONE_FREE;
                                state_next      = S_SCAN;
                            end
                        end
                        vsa_pkg::OP_FREE,
                        vsa_pkg::OP_SET_PRI,
                        vsa_pkg::OP_HANDLER,
                        vsa_pkg::OP_PLAY,
                        vsa_pkg::OP_STOP:
                        begin
                            if (req_in_range)
                            begin
                                state_next = S_ONE;
                            end
                            else
                            begin
                                if (req.opcode == vsa_pkg::OP_FREE)
                                begin
                                    res_status_next = vsa_pkg::RC_BAD_OWNER;
                                end
                                state_next = S_RESP;
                            end
                        end
                        vsa_pkg::OP_BRK_LO,
                        vsa_pkg::OP_BRK_ACT,
                        vsa_pkg::OP_TICK:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue_reg)
                begin
                    rd_addr       = rd_idx_reg;
                    ev_valid_next = 1'b1;
                    ev_idx_next   = rd_idx_reg;
                    ev_last_next  = (rd_idx_reg == LAST_IDX);
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (ev_valid_reg)
                begin
                    case (op_reg)
                        vsa_pkg::OP_ALLOC:
                        begin
                            if (rd_rec.status == vsa_pkg::ST_FREE)
                            begin
                                wr_en           = 1'b1;
                                wr_rec.status   = vsa_pkg::ST_ALLOC;
                                wr_rec.owner    = own_reg;
                                wr_rec.pri      = 8'd1;
                                wr_rec.active   = 1'b0;
                                wr_rec.fstop    = 1'b0;
                                wr_rec.age      = '0;
                                free_cnt_next   = free_cnt_reg - 1'b1;
                                use_cnt_next    = use_cnt_reg + 1'b1;
                                res_status_next = vsa_pkg::RC_OK;
                                res_slot_next   = ev_idx_reg;
                                issue_next      = 1'b0;
                                ev_valid_next   = 1'b0;
                                state_next      = S_RESP;
                            end
                            else if (ev_last_reg)
                            begin
                                state_next = S_RESP;
                            end
                        end
                        vsa_pkg::OP_TICK:
                        begin
                            if ((rd_rec.status != vsa_pkg::ST_FREE) && !rd_rec.fstop)
                            begin
                                wr_en      = 1'b1;
                                wr_rec.age = rd_rec.age + 1'b1;
                            end
                            if (ev_last_reg)
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            // victim search for both break operations
                            if (take_free && (rd_rec.status == vsa_pkg::ST_FREE))
                            begin
                                vic_idx_next  = ev_idx_reg;
                                vic_rec_next  = rd_rec;
                                issue_next    = 1'b0;
                                ev_valid_next = 1'b0;
                                state_next    = S_DECIDE;
                            end
                            else
                            begin
                                if (is_cand)
                                begin
                                    vic_idx_next = ev_idx_reg;
                                    vic_rec_next = rd_rec;
                                    cmp_pri_next = rd_rec.pri;
                                    cmp_age_next = rd_rec.age;
                                end
                                else if (ev_idx_reg == '0)
                                begin
                                    // no candidate yet: victim defaults to slot 0
                                    vic_idx_next = '0;
                                    vic_rec_next = rd_rec;
                                    cmp_pri_next = vsa_pkg::PRI_START;
                                    cmp_age_next = '0;
                                end
                                if (ev_last_reg)
                                begin
                                    state_next = S_DECIDE;
                                end
                            end
                        end
                    endcase
                end
            end

            S_ONE:
            begin
                wr_addr    = idx_reg;
                state_next = S_RESP;
                case (op_reg)
                    vsa_pkg::OP_FREE:
                    begin
                        if (rd_rec.owner != own_reg)
                        begin
                            res_status_next = vsa_pkg::RC_BAD_OWNER;
                        end
                        else
                        begin
                            if (rd_rec.status == vsa_pkg::ST_ALLOC)
                            begin
                                use_cnt_next = use_cnt_reg - 1'b1;
                            end
                            if (rd_rec.status != vsa_pkg::ST_FREE)
                            begin
                                free_cnt_next = free_cnt_reg + 1'b1;
                            end
                            if (rd_rec.status == vsa_pkg::ST_STOP)
                            begin
                                stop_cnt_next = stop_cnt_reg - 1'b1;
                            end
                            wr_en          = 1'b1;
                            wr_rec.status  = vsa_pkg::ST_FREE;
                            wr_rec.pri     = 8'd0;
                            wr_rec.handler = 1'b0;
                            wr_rec.owner   = '0;
                        end
                    end
                    vsa_pkg::OP_SET_PRI:
                    begin
                        wr_en      = 1'b1;
                        wr_rec.pri = val_reg;
                    end
                    vsa_pkg::OP_HANDLER:
                    begin
                        wr_en          = 1'b1;
                        wr_rec.handler = (val_reg != 8'd0);
                    end
                    vsa_pkg::OP_PLAY:
                    begin
                        wr_en         = 1'b1;
                        wr_rec.active = 1'b1;
                        wr_rec.fstop  = 1'b0;
                        wr_rec.age    = '0;
                    end
                    vsa_pkg::OP_STOP:
                    begin
                        wr_en         = 1'b1;
                        wr_rec.active = 1'b0;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end

            S_DECIDE:
            begin
                wr_addr       = vic_idx_reg;
                wr_rec        = vic_rec_reg;
                res_slot_next = vic_idx_reg;
                state_next    = S_RESP;
                if ((vic_rec_reg.pri > val_reg) || (vic_rec_reg.status == vsa_pkg::ST_FREE))
                begin
                    res_status_next = vsa_pkg::RC_REFUSED;
                end
                else
                begin
                    res_status_next = vsa_pkg::RC_OK;
                    res_note_next   = vic_rec_reg.handler;
                    if ((vic_rec_reg.status == vsa_pkg::ST_ALLOC) && vic_rec_reg.active)
                    begin
                        wr_en         = 1'b1;
                        wr_rec.status = vsa_pkg::ST_STOP;
                        wr_rec.fstop  = 1'b1;
                        use_cnt_next  = use_cnt_reg - 1'b1;
                        stop_cnt_next = stop_cnt_reg + 1'b1;
                    end
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.status_code     = res_status_reg;
                    rsp_next.result_slot     = 6'(res_slot_reg);
                    rsp_next.victim_notified = res_note_reg;
                    rsp_next.free_count      = 7'(free_cnt_reg);
                    rsp_next.use_count       = 7'(use_cnt_reg);
                    rsp_next.break_count     = 7'(stop_cnt_reg);
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            issue_reg     <= 1'b0;
            ev_valid_reg  <= 1'b0;
            free_cnt_reg  <= CNT_W'(NUM_SLOTS);
            use_cnt_reg   <= '0;
            stop_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            issue_reg     <= issue_next;
            ev_valid_reg  <= ev_valid_next;
            free_cnt_reg  <= free_cnt_next;
            use_cnt_reg   <= use_cnt_next;
            stop_cnt_reg  <= stop_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        own_reg        <= own_next;
        val_reg        <= val_next;
        rd_idx_reg     <= rd_idx_next;
        ev_idx_reg     <= ev_idx_next;
        ev_last_reg    <= ev_last_next;
        vic_idx_reg    <= vic_idx_next;
        vic_rec_reg    <= vic_rec_next;
        cmp_pri_reg    <= cmp_pri_next;
        cmp_age_reg    <= cmp_age_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_note_reg   <= res_note_next;
        rsp_reg        <= rsp_next;
    end

`include "assert_macros.svh"

    // every slot is free, in use or stopped
    `VSA_CHECK(a_counts_cover_pool, clk, rst_n, pool_ok)
    // the RAM is never written while idle or responding
    `VSA_CHECK(a_no_write_idle, clk, rst_n, !(wr_en && (state_reg == S_IDLE || state_reg == S_RESP)))
    // a new response word only follows the respond step
    `VSA_CHECK(a_rsp_from_resp, clk, rst_n, $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))

endmodule

`default_nettype wire

// ===== src/vsa_slot_ram.sv =====
`default_nettype none

// slot record store: one write port, one read port, registered read data
module vsa_slot_ram #(
    parameter int DEPTH = vsa_pkg::DEF_NUM_SLOTS,
    parameter int WIDTH = 8,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== tb/tb_voice_slot_allocator_with_stealing.sv =====
`default_nettype none

module tb_voice_slot_allocator_with_stealing;

    localparam int SLOTS     = 64;
    localparam int WDOG_MAX  = 20000;  // cycles with no word accepted
    localparam int RAND_WORDS = 1470;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    vsa_pkg::req_word_t req;
    logic               rsp_valid;
    logic               rsp_stall;
    vsa_pkg::rsp_word_t rsp;

    voice_slot_allocator_with_stealing i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the slot pool
    // ---------------------------------------------------------------
    logic [1:0]  sh_status [SLOTS];
    logic [31:0] sh_owner  [SLOTS];
    logic [7:0]  sh_pri    [SLOTS];
    logic        sh_hdl    [SLOTS];
    logic        sh_act    [SLOTS];
    logic        sh_fstop  [SLOTS];
    logic [31:0] sh_age    [SLOTS];
    int          sh_free;
    int          sh_use;

    vsa_pkg::req_word_t pending_words[$];   // words waiting to be driven
    vsa_pkg::rsp_word_t expected_rsp[$];    // predicted responses, oldest first

    int  n_errors   = 0;
    int  n_accepted = 0;
    int  n_checked  = 0;
    int  n_refused  = 0;
    int  n_stolen   = 0;
    bit  quiet_tail = 1'b0;        // no idling once set

    function automatic void reset_pool();
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_status[i] = vsa_pkg::ST_FREE;
            sh_owner[i]  = '0;
            sh_pri[i]    = '0;
            sh_hdl[i]    = 1'b0;
            sh_act[i]    = 1'b0;
            sh_fstop[i]  = 1'b0;
            sh_age[i]    = '0;
        end
        sh_free = SLOTS;
        sh_use  = 0;
    endfunction

    // victim search: first free slot when taking free ones, else lowest
    // priority, ties to greater age, then to the higher index
    function automatic int pick_victim(bit lower);
        int         best;
        logic [7:0] bpri;
        logic [31:0] bage;
        best = 0;
        bpri = vsa_pkg::PRI_START;
        bage = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (lower && sh_status[i] == vsa_pkg::ST_FREE)
                return i;
            if (sh_status[i] != vsa_pkg::ST_ALLOC)
                continue;
            if (lower && !sh_hdl[i])
                continue;
            if (sh_pri[i] <= bpri && (sh_pri[i] != bpri || sh_age[i] >= bage))
            begin
                best = i;
                bpri = sh_pri[i];
                bage = sh_age[i];
            end
        end
        return best;
    endfunction

    function automatic vsa_pkg::rsp_word_t apply_request(vsa_pkg::req_word_t w);
        vsa_pkg::rsp_word_t r;
        int        s;
        int        v;
        int        nstop;
        r = '0;
        s = w.slot;
        case (w.opcode)
            vsa_pkg::OP_ALLOC:
            begin
                if (w.value != 0)
                    r.status_code = vsa_pkg::RC_MULTI;
                else
                begin
                    r.status_code = vsa_pkg::RC_NONE_FREE;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (sh_status[i] == vsa_pkg::ST_FREE)
                        begin
                            sh_status[i] = vsa_pkg::ST_ALLOC;
                            sh_owner[i]  = w.owner;
                            sh_pri[i]    = 8'd1;
                            sh_act[i]    = 1'b0;
                            sh_fstop[i]  = 1'b0;
                            sh_age[i]    = '0;
                            sh_free--;
                            sh_use++;
                            r.status_code = vsa_pkg::RC_OK;
                            r.result_slot = i[5:0];
                            break;
                        end
                    end
                end
            end
            vsa_pkg::OP_FREE:
            begin
                if (sh_owner[s] != w.owner)
                    r.status_code = vsa_pkg::RC_BAD_OWNER;
                else
                begin
                    if (sh_status[s] == vsa_pkg::ST_ALLOC)
                        sh_use--;
                    if (sh_status[s] != vsa_pkg::ST_FREE)
                        sh_free++;
                    sh_status[s] = vsa_pkg::ST_FREE;
                    sh_pri[s]    = '0;
                    sh_hdl[s]    = 1'b0;
                    sh_owner[s]  = '0;
                end
            end
            vsa_pkg::OP_SET_PRI: sh_pri[s] = w.value;
            vsa_pkg::OP_HANDLER: sh_hdl[s] = (w.value != 0);
            vsa_pkg::OP_PLAY:
            begin
                sh_act[s]   = 1'b1;
                sh_fstop[s] = 1'b0;
                sh_age[s]   = '0;
            end
            vsa_pkg::OP_STOP: sh_act[s] = 1'b0;
            vsa_pkg::OP_BRK_LO, vsa_pkg::OP_BRK_ACT:
            begin
                v = pick_victim(w.opcode == vsa_pkg::OP_BRK_LO);
                r.result_slot = v[5:0];
                if (sh_pri[v] > w.value || sh_status[v] == vsa_pkg::ST_FREE)
                begin
                    r.status_code = vsa_pkg::RC_REFUSED;
                    n_refused++;
                end
                else
                begin
                    r.victim_notified = sh_hdl[v];
                    if (sh_status[v] == vsa_pkg::ST_ALLOC && sh_act[v])
                    begin
                        sh_use--;
                        sh_fstop[v]  = 1'b1;
                        sh_status[v] = vsa_pkg::ST_STOP;
                        n_stolen++;
                    end
                end
            end
            vsa_pkg::OP_TICK:
                for (int i = 0; i < SLOTS; i++)
                    if (sh_status[i] != vsa_pkg::ST_FREE && !sh_fstop[i])
                        sh_age[i] = sh_age[i] + 32'd1;
            default: ;
        endcase
        nstop = 0;
        for (int i = 0; i < SLOTS; i++)
            if (sh_status[i] == vsa_pkg::ST_STOP)
                nstop++;
        r.free_count  = sh_free[6:0];
        r.use_count   = sh_use[6:0];
        r.break_count = nstop[6:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver: takes words from pending_words, idles in short bursts
    // ---------------------------------------------------------------
    int req_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(apply_request(req));
                n_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 7) == 0)
                begin
                    req_gap = $urandom_range(0, 3);
                    req_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    req       <= pending_words.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each accepted response, stalls in short bursts
    // ---------------------------------------------------------------
    int rsp_burst = 0;

    always @(posedge clk or negedge rst_n)
    begin
        vsa_pkg::rsp_word_t exp_w;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_burst = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_checked++;
                if (expected_rsp.size() == 0)
                begin
                    $error("response word with nothing expected");
                    n_errors++;
                end
                else
                begin
                    exp_w = expected_rsp.pop_front();
                    if (rsp.status_code !== exp_w.status_code)
                    begin
                        $error("status_code exp %0d got %0d", exp_w.status_code,
                               rsp.status_code);
                        n_errors++;
                    end
                    if (rsp.result_slot !== exp_w.result_slot)
                    begin
                        $error("result_slot exp %0d got %0d", exp_w.result_slot,
                               rsp.result_slot);
                        n_errors++;
                    end
                    if (rsp.victim_notified !== exp_w.victim_notified)
                    begin
                        $error("victim_notified exp %0d got %0d",
                               exp_w.victim_notified, rsp.victim_notified);
                        n_errors++;
                    end
                    if (rsp.free_count !== exp_w.free_count)
                    begin
                        $error("free_count exp %0d got %0d", exp_w.free_count,
                               rsp.free_count);
                        n_errors++;
                    end
                    if (rsp.use_count !== exp_w.use_count)
                    begin
                        $error("use_count exp %0d got %0d", exp_w.use_count,
                               rsp.use_count);
                        n_errors++;
                    end
                    if (rsp.break_count !== exp_w.break_count)
                    begin
                        $error("break_count exp %0d got %0d", exp_w.break_count,
                               rsp.break_count);
                        n_errors++;
                    end
                end
            end
            if (rsp_burst > 0)
            begin
                rsp_burst--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                rsp_burst = $urandom_range(0, 3);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // watchdog: counts cycles with no word accepted on either side
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic vsa_pkg::req_word_t mk(logic [3:0] op, int s, logic [31:0] own,
                                              logic [7:0] val);
        vsa_pkg::req_word_t w;
        w.opcode = op;
        w.slot   = s[5:0];
        w.owner  = own;
        w.value  = val;
        return w;
    endfunction

    // owner tags handed out, so that most frees match
    logic [31:0] tag_of [SLOTS];

    function automatic logic [3:0] rand_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 20) return vsa_pkg::OP_ALLOC;
        if (k < 32) return vsa_pkg::OP_FREE;
        if (k < 42) return vsa_pkg::OP_SET_PRI;
        if (k < 50) return vsa_pkg::OP_HANDLER;
        if (k < 62) return vsa_pkg::OP_PLAY;
        if (k < 67) return vsa_pkg::OP_STOP;
        if (k < 77) return vsa_pkg::OP_BRK_LO;
        if (k < 87) return vsa_pkg::OP_BRK_ACT;
        if (k < 97) return vsa_pkg::OP_TICK;
        return 4'($urandom_range(9, 15));  // unused opcodes
    endfunction

    initial
    begin
        vsa_pkg::req_word_t w;
        logic [31:0] own;
        int s;
        reset_pool();
        for (int i = 0; i < SLOTS; i++)
            tag_of[i] = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-pool breaks (default slot 0, free victim),
        // multichannel alloc, bad owner, unknown opcode
        pending_words.push_back(mk(vsa_pkg::OP_BRK_ACT, 0, 0, 8'hff));
        pending_words.push_back(mk(vsa_pkg::OP_BRK_LO, 0, 0, 8'h00));
        pending_words.push_back(mk(vsa_pkg::OP_ALLOC, 0, 32'hffffffff, 8'h01));
        pending_words.push_back(mk(vsa_pkg::OP_FREE, 63, 32'h1, 8'h00));
        pending_words.push_back(mk(vsa_pkg::OP_FREE, 5, 32'h0, 8'h00)); // free slot, owner 0
        pending_words.push_back(mk(4'd15, 63, 32'hffffffff, 8'hff));
        pending_words.push_back(mk(vsa_pkg::OP_ALLOC, 0, 32'hffffffff, 8'h00));
        pending_words.push_back(mk(vsa_pkg::OP_ALLOC, 0, 32'h00000000, 8'h00));
        pending_words.push_back(mk(vsa_pkg::OP_PLAY, 0, 0, 0));
        pending_words.push_back(mk(vsa_pkg::OP_HANDLER, 0, 0, 8'h80));
        pending_words.push_back(mk(vsa_pkg::OP_SET_PRI, 1, 0, 8'hff));
        pending_words.push_back(mk(vsa_pkg::OP_TICK, 0, 0, 0));
        pending_words.push_back(mk(vsa_pkg::OP_BRK_LO, 0, 0, 8'h00));   // free slot wins
        pending_words.push_back(mk(vsa_pkg::OP_BRK_ACT, 0, 0, 8'h00));  // priority too high
        pending_words.push_back(mk(vsa_pkg::OP_BRK_ACT, 0, 0, 8'h01));  // steals slot 0
        pending_words.push_back(mk(vsa_pkg::OP_TICK, 0, 0, 0));         // stopped slot not aged
        pending_words.push_back(mk(vsa_pkg::OP_PLAY, 0, 0, 0));         // play on stopped slot
        pending_words.push_back(mk(vsa_pkg::OP_BRK_ACT, 0, 0, 8'hff));  // inactive victim
        pending_words.push_back(mk(vsa_pkg::OP_STOP, 1, 0, 0));
        pending_words.push_back(mk(vsa_pkg::OP_FREE, 0, 32'hffffffff, 0));
        pending_words.push_back(mk(vsa_pkg::OP_FREE, 1, 32'h0, 0));
        tag_of[0] = '0;

        // fill the pool completely, then try once more
        for (int i = 0; i < SLOTS; i++)
        begin
            tag_of[i] = $urandom;
            pending_words.push_back(mk(vsa_pkg::OP_ALLOC, 0, tag_of[i], 8'h00));
        end
        pending_words.push_back(mk(vsa_pkg::OP_ALLOC, 0, 32'h5a5a5a5a, 8'h00));
        for (int i = 0; i < SLOTS; i += 3)
        begin
            pending_words.push_back(mk(vsa_pkg::OP_PLAY, i, 0, 0));
            pending_words.push_back(mk(vsa_pkg::OP_HANDLER, i, 0, 8'h01));
        end
        pending_words.push_back(mk(vsa_pkg::OP_BRK_LO, 0, 0, 8'h01));

        // random part; mostly matching owners and small slot pool pressure
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            w.opcode = rand_op();
            s = $urandom_range(0, SLOTS - 1);
            w.slot = s[5:0];
            w.owner = $urandom;
            w.value = 8'($urandom);
            case (w.opcode)
                vsa_pkg::OP_ALLOC:
                begin
                    if ($urandom_range(0, 9) != 0)
                        w.value = '0;
                end
                vsa_pkg::OP_FREE:
                    if ($urandom_range(0, 5) != 0)
                        w.owner = tag_of[s];
                vsa_pkg::OP_SET_PRI:
                    if ($urandom_range(0, 2) != 0)
                        w.value = 8'($urandom_range(0, 4));
                vsa_pkg::OP_HANDLER:
                    if ($urandom_range(0, 1) != 0)
                        w.value = '0;
                default: ;
            endcase
            pending_words.push_back(w);
        end

        // owners handed out are unknown up front; record on alloc instead
        fork
            forever
            begin
                @(posedge clk);
                if (req_valid && !req_stall && req.opcode == vsa_pkg::OP_ALLOC
                    && req.value == 8'd0)
                begin
                    own = req.owner;
                    #0;
                    if (expected_rsp.size() > 0
                        && expected_rsp[$].status_code == vsa_pkg::RC_OK)
                        tag_of[expected_rsp[$].result_slot] = own;
                end
            end
        join_none

        wait (pending_words.size() < 200);
        quiet_tail = 1'b1;
        wait (pending_words.size() == 0 && !req_valid);
        wait (expected_rsp.size() == 0);
        repeat (SLOTS * 2) @(posedge clk);

        $display("Checked %0d of %0d request words: %0d breaks refused, %0d voices stolen",
                 n_checked, n_accepted, n_refused, n_stolen);
        if (n_errors == 0 && expected_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/vsa_pkg.sv
src/vsa_slot_ram.sv
src/voice_slot_allocator_with_stealing.sv
tb/tb_voice_slot_allocator_with_stealing.sv
